>>> src/bia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bia_pkg;

    // Port field widths
    localparam int OP_WIDTH       = 4;
    localparam int FIELD_WIDTH    = 32;
    localparam int BIA_DATA_WIDTH = 32;

    // Operator codes
    localparam logic [OP_WIDTH-1:0] OP_ADD = 4'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB = 4'd1;
    localparam logic [OP_WIDTH-1:0] OP_MUL = 4'd2;
    localparam logic [OP_WIDTH-1:0] OP_DIV = 4'd3;
    localparam logic [OP_WIDTH-1:0] OP_MOD = 4'd4;
    localparam logic [OP_WIDTH-1:0] OP_NEG = 4'd5;
    localparam logic [OP_WIDTH-1:0] OP_NOT = 4'd6;
    localparam logic [OP_WIDTH-1:0] OP_OR  = 4'd7;
    localparam logic [OP_WIDTH-1:0] OP_AND = 4'd8;
    localparam logic [OP_WIDTH-1:0] OP_EQ  = 4'd9;
    localparam logic [OP_WIDTH-1:0] OP_LE  = 4'd10;
    localparam logic [OP_WIDTH-1:0] OP_GE  = 4'd11;
    localparam logic [OP_WIDTH-1:0] OP_NE  = 4'd12;
    localparam logic [OP_WIDTH-1:0] OP_GT  = 4'd13;
    localparam logic [OP_WIDTH-1:0] OP_LT  = 4'd14;

    // What each cell of the chain does with the item
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_MUL  = 2'd1;
    localparam logic [1:0] MODE_DIV  = 2'd2;

    // Control that travels with each item down the chain
    typedef struct packed {
        logic [1:0] mode;     // cell action
        logic       is_mod;   // divide op delivers the remainder
        logic       neg_res;  // negate the unsigned divide result at the end
        logic       err;      // divide by zero
    } t_ctrl;

endpackage

`default_nettype wire

>>> src/bia_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bia_front #(
    parameter int DATA_WIDTH = bia_pkg::BIA_DATA_WIDTH
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire  [bia_pkg::OP_WIDTH-1:0]      i_req_type,
    input  wire  [bia_pkg::FIELD_WIDTH-1:0]   i_operand_a,
    input  wire  [bia_pkg::FIELD_WIDTH-1:0]   i_operand_b,
    output logic                              o_valid,
    input  wire                               i_ready,
    output bia_pkg::t_ctrl                    o_ctrl,
    output logic [DATA_WIDTH-1:0]             o_p,
    output logic [DATA_WIDTH-1:0]             o_q,
    output logic [DATA_WIDTH-1:0]             o_d
);
    import bia_pkg::*;

    logic [DATA_WIDTH-1:0] w_a;
    logic [DATA_WIDTH-1:0] w_b;
    logic [DATA_WIDTH-1:0] w_mag_a;
    logic [DATA_WIDTH-1:0] w_mag_b;
    logic                  w_eq;
    logic                  w_lt;

    logic                  r_valid;
    t_ctrl                 r_ctrl;
    logic [DATA_WIDTH-1:0] r_p;
    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] r_d;

    t_ctrl                 n_ctrl;
    logic [DATA_WIDTH-1:0] n_p;
    logic [DATA_WIDTH-1:0] n_q;
    logic [DATA_WIDTH-1:0] n_d;

    // Bring operands to the working width
    generate
        if (DATA_WIDTH > FIELD_WIDTH) begin : g_ext
            assign w_a = {{(DATA_WIDTH-FIELD_WIDTH){i_operand_a[FIELD_WIDTH-1]}}, i_operand_a};
            assign w_b = {{(DATA_WIDTH-FIELD_WIDTH){i_operand_b[FIELD_WIDTH-1]}}, i_operand_b};
        end else begin : g_cut
            assign w_a = i_operand_a[DATA_WIDTH-1:0];
            assign w_b = i_operand_b[DATA_WIDTH-1:0];
        end
    endgenerate

    // Magnitudes for the unsigned divider; the minimum value maps to 2^(W-1)
    assign w_mag_a = w_a[DATA_WIDTH-1] ? (~w_a + 1'b1) : w_a;
    assign w_mag_b = w_b[DATA_WIDTH-1] ? (~w_b + 1'b1) : w_b;

    assign w_eq = (w_a == w_b);
    assign w_lt = ($signed(w_a) < $signed(w_b));

    // Decode: one-shot ops finish here, mul and div are set up for the chain
    always_comb begin
        n_ctrl = '0;
        n_ctrl.mode = MODE_PASS;
        n_p = '0;
        n_q = '0;
        n_d = '0;
        case (i_req_type)
            OP_ADD: n_p = w_a + w_b;
            OP_SUB: n_p = w_a - w_b;
            OP_MUL: begin
                n_ctrl.mode = MODE_MUL;
                n_q = w_b;
                n_d = w_a;
            end
            OP_DIV, OP_MOD: begin
                if (w_b == '0) begin
                    n_ctrl.err = 1'b1;
                end else begin
                    n_ctrl.mode    = MODE_DIV;
                    n_ctrl.is_mod  = (i_req_type == OP_MOD);
                    n_ctrl.neg_res = (i_req_type == OP_MOD) ? w_a[DATA_WIDTH-1]
                                   : (w_a[DATA_WIDTH-1] ^ w_b[DATA_WIDTH-1]);
                    n_q = w_mag_a;
                    n_d = w_mag_b;
                end
            end
            OP_NEG: n_p = ~w_b + 1'b1;
            OP_NOT: n_p = ~w_b;
            OP_OR:  n_p = w_a | w_b;
            OP_AND: n_p = w_a & w_b;
            OP_EQ:  n_p = {DATA_WIDTH{w_eq}};
            OP_LE:  n_p = {DATA_WIDTH{w_lt | w_eq}};
            OP_GE:  n_p = {DATA_WIDTH{~w_lt}};
            OP_NE:  n_p = {DATA_WIDTH{~w_eq}};
            OP_GT:  n_p = {DATA_WIDTH{~w_lt & ~w_eq}};
            OP_LT:  n_p = {DATA_WIDTH{w_lt}};
            default: n_p = '0;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctrl <= n_ctrl;
            r_p    <= n_p;
            r_q    <= n_q;
            r_d    <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_p     = r_p;
    assign o_q     = r_q;
    assign o_d     = r_d;

endmodule

`default_nettype wire

>>> src/bia_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bia_cell #(
    parameter int DATA_WIDTH = bia_pkg::BIA_DATA_WIDTH
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire bia_pkg::t_ctrl   i_ctrl,
    input  wire  [DATA_WIDTH-1:0] i_p,
    input  wire  [DATA_WIDTH-1:0] i_q,
    input  wire  [DATA_WIDTH-1:0] i_d,
    output logic                  o_valid,
    input  wire                   i_ready,
    output bia_pkg::t_ctrl        o_ctrl,
    output logic [DATA_WIDTH-1:0] o_p,
    output logic [DATA_WIDTH-1:0] o_q,
    output logic [DATA_WIDTH-1:0] o_d
);
    import bia_pkg::*;

    logic [DATA_WIDTH:0]   w_shift;
    logic [DATA_WIDTH:0]   w_diff;

    logic                  r_valid;
    t_ctrl                 r_ctrl;
    logic [DATA_WIDTH-1:0] r_p;
    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] r_d;

    logic [DATA_WIDTH-1:0] n_p;
    logic [DATA_WIDTH-1:0] n_q;
    logic [DATA_WIDTH-1:0] n_d;

    // Restoring divide step: shift in next dividend bit, trial subtract
    assign w_shift = {i_p, i_q[DATA_WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, i_d};

    // One step of shift-add multiply or restoring divide
    always_comb begin
        n_p = i_p;
        n_q = i_q;
        n_d = i_d;
        case (i_ctrl.mode)
            MODE_MUL: begin
                // p: product, q: multiplier bits, d: shifted multiplicand
                n_p = i_q[0] ? (i_p + i_d) : i_p;
                n_q = i_q >> 1;
                n_d = i_d << 1;
            end
            MODE_DIV: begin
                // p: remainder, q: dividend in / quotient out, d: divisor
                if (!w_diff[DATA_WIDTH]) begin
                    n_p = w_diff[DATA_WIDTH-1:0];
                    n_q = {i_q[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    n_p = w_shift[DATA_WIDTH-1:0];
                    n_q = {i_q[DATA_WIDTH-2:0], 1'b0};
                end
            end
            default: begin
                n_p = i_p;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    // Cell valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Cell payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctrl <= i_ctrl;
            r_p    <= n_p;
            r_q    <= n_q;
            r_d    <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_p     = r_p;
    assign o_q     = r_q;
    assign o_d     = r_d;

endmodule

`default_nettype wire

>>> src/basic_integer_operator_alu_top.sv
// Channel  | valid        | ready        | payload
// ---------+--------------+--------------+-------------------------------------
// in       | i_in_valid   | o_in_ready   | i_req_type, i_operand_a, i_operand_b
// out      | o_out_valid  | i_out_ready  | o_result_value, o_error_code
//
// One item per cycle sustained while the output is not stalled; a result passes
// DATA_WIDTH + 2 registers after its input transfer: a decode register,
// DATA_WIDTH step cells (one multiply or divide bit each) and the output register.
// Every stage has its own ready, so an empty stage is filled even while the
// output is stalled; ready is combinational back through the whole chain, and with
// the output stalled the input stalls once DATA_WIDTH + 2 items are held.
// Synchronous active-low reset empties all stages.
`timescale 1ns / 1ps
`default_nettype none

module basic_integer_operator_alu_top #(
    parameter int DATA_WIDTH = bia_pkg::BIA_DATA_WIDTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [bia_pkg::OP_WIDTH-1:0]     i_req_type,
    input  wire  [bia_pkg::FIELD_WIDTH-1:0]  i_operand_a,
    input  wire  [bia_pkg::FIELD_WIDTH-1:0]  i_operand_b,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [bia_pkg::FIELD_WIDTH-1:0]  o_result_value,
    output logic                             o_error_code
);
    import bia_pkg::*;

    logic [DATA_WIDTH:0]   w_valid;
    logic [DATA_WIDTH:0]   w_ready;
    t_ctrl                 w_ctrl [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_p    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_q    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_d    [0:DATA_WIDTH];

    t_ctrl                 w_last;
    logic [DATA_WIDTH-1:0] w_mag;
    logic [DATA_WIDTH-1:0] w_res;
    logic [FIELD_WIDTH-1:0] n_result;

    logic                  r_out_valid;
    logic [FIELD_WIDTH-1:0] r_result;
    logic                  r_err;

    // Decode stage
    bia_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_req_type  (i_req_type),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (w_valid[0]),
        .i_ready     (w_ready[0]),
        .o_ctrl      (w_ctrl[0]),
        .o_p         (w_p[0]),
        .o_q         (w_q[0]),
        .o_d         (w_d[0])
    );

    // Chain of step cells, one bit of multiply or divide per cell
    generate
        for (genvar gi = 0; gi < DATA_WIDTH; gi++) begin : g_cell
            bia_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[gi]),
                .o_ready (w_ready[gi]),
                .i_ctrl  (w_ctrl[gi]),
                .i_p     (w_p[gi]),
                .i_q     (w_q[gi]),
                .i_d     (w_d[gi]),
                .o_valid (w_valid[gi+1]),
                .i_ready (w_ready[gi+1]),
                .o_ctrl  (w_ctrl[gi+1]),
                .o_p     (w_p[gi+1]),
                .o_q     (w_q[gi+1]),
                .o_d     (w_d[gi+1])
            );
        end
    endgenerate

    // Final fix-up: pick quotient or remainder and restore the sign
    assign w_last = w_ctrl[DATA_WIDTH];
    assign w_mag  = w_last.is_mod ? w_p[DATA_WIDTH] : w_q[DATA_WIDTH];

    always_comb begin
        if (w_last.mode == MODE_DIV) begin
            w_res = w_last.neg_res ? (~w_mag + 1'b1) : w_mag;
        end else begin
            w_res = w_p[DATA_WIDTH];
        end
    end

    // Back to the 32-bit port width
    generate
        if (DATA_WIDTH < FIELD_WIDTH) begin : g_res_ext
            assign n_result = {{(FIELD_WIDTH-DATA_WIDTH){w_res[DATA_WIDTH-1]}}, w_res};
        end else begin : g_res_cut
            assign n_result = w_res[FIELD_WIDTH-1:0];
        end
    endgenerate

    // Output register
    assign w_ready[DATA_WIDTH] = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[DATA_WIDTH]) begin
            r_out_valid <= w_valid[DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[DATA_WIDTH] && w_valid[DATA_WIDTH]) begin
            r_result <= n_result;
            r_err    <= w_last.err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;
    assign o_error_code   = r_err;

`ifndef SYNTHESIS
    // Divide by zero always delivers a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code |-> o_result_value == '0)
        else $error("divide-by-zero result not zero");

    // A transfer in lands in the decode stage
    a_front_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> w_valid[0])
        else $error("accepted item missing from decode stage");

    // A result entering the output register shows on the port
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[DATA_WIDTH] && w_ready[DATA_WIDTH] |=> o_out_valid)
        else $error("result lost at output register");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire
